>>> rtl/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// shared types and constants for the mersenne divisor check block
// ----------------------------------------------------------------------------
`default_nettype none

package mdc_pkg;

  // operand width of exponent, modulus and residue
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned MBIT_W         = $clog2(DATA_W);
  localparam int unsigned WORD_BITS_DEF  = 32;
  localparam int unsigned IN_TDATA_W     = 2 * DATA_W;
  localparam int unsigned OUT_TDATA_W    = DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_DBL,
    ST_MUL_ADD,
    ST_WRITE,
    ST_FINISH
  } mdc_state_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              mul_clr;
    logic              mul_dbl;
    logic              mul_add;
    logic              wr_acc;
    logic              wr_sq;
    logic              shift_exp;
    logic              out_load;
    logic              sel_sq;
    logic [MBIT_W-1:0] mbit;
  } mdc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic exp_lsb;
    logic exp_zero;
    logic mod_small;
  } mdc_status_t;

endpackage

`default_nettype wire

>>> rtl/mdc_ctrl.sv
// ----------------------------------------------------------------------------
// mdc_ctrl
// sequencer for square-and-multiply with a bit-serial modular multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_ctrl
  import mdc_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire mdc_status_t status,
  output mdc_cmd_t         cmd
);

  // exponent bits above the operand width are zero and never change the residue
  localparam int unsigned SCAN_BITS = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
  localparam int unsigned EBIT_W    = $clog2(SCAN_BITS + 1);
  localparam logic [EBIT_W-1:0] EBIT_LAST = EBIT_W'(SCAN_BITS);
  localparam logic [MBIT_W-1:0] MBIT_MSB  = MBIT_W'(DATA_W - 1);

  mdc_state_t        state_r, state_nxt;
  logic [MBIT_W-1:0] mbit_r, mbit_nxt;
  logic [EBIT_W-1:0] ebit_r, ebit_nxt;
  logic              tgt_sq_r, tgt_sq_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              scan_done;

  assign out_free  = !out_valid_r || out_tready;
  assign scan_done = status.mod_small || status.exp_zero || (ebit_r == EBIT_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mbit_r      <= '0;
      ebit_r      <= '0;
      tgt_sq_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mbit_r      <= mbit_nxt;
      ebit_r      <= ebit_nxt;
      tgt_sq_r    <= tgt_sq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_tvalid) state_nxt = ST_CHECK;
      ST_CHECK:   state_nxt = scan_done ? ST_FINISH : ST_MUL_DBL;
      ST_MUL_DBL: state_nxt = ST_MUL_ADD;
      ST_MUL_ADD: state_nxt = (mbit_r == '0) ? ST_WRITE : ST_MUL_DBL;
      ST_WRITE:   state_nxt = tgt_sq_r ? ST_CHECK : ST_MUL_DBL;
      ST_FINISH:  if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    cmd           = '0;
    cmd.sel_sq    = tgt_sq_r;
    cmd.mbit      = mbit_r;
    mbit_nxt      = mbit_r;
    ebit_nxt      = ebit_r;
    tgt_sq_nxt    = tgt_sq_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          ebit_nxt = '0;
        end
      end
      ST_CHECK: begin
        if (!scan_done) begin
          // set bit: multiply into acc first, else square only
          tgt_sq_nxt  = !status.exp_lsb;
          cmd.mul_clr = 1'b1;
          mbit_nxt    = MBIT_MSB;
        end
      end
      ST_MUL_DBL: cmd.mul_dbl = 1'b1;
      ST_MUL_ADD: begin
        cmd.mul_add = 1'b1;
        if (mbit_r != '0) mbit_nxt = mbit_r - MBIT_W'(1);
      end
      ST_WRITE: begin
        if (tgt_sq_r) begin
          cmd.wr_sq     = 1'b1;
          cmd.shift_exp = 1'b1;
          ebit_nxt      = ebit_r + EBIT_W'(1);
        end else begin
          cmd.wr_acc  = 1'b1;
          tgt_sq_nxt  = 1'b1;
          cmd.mul_clr = 1'b1;
          mbit_nxt    = MBIT_MSB;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/mdc_dp.sv
// ----------------------------------------------------------------------------
// mdc_dp
// operand registers and a shift-add modular multiplier, one step per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_dp
  import mdc_pkg::*;
(
  input  wire logic              clk,
  input  wire mdc_cmd_t          cmd,
  input  wire logic [DATA_W-1:0] exponent,
  input  wire logic [DATA_W-1:0] modulus,
  output mdc_status_t            status,
  output logic [DATA_W-1:0]      residue,
  output logic                   divides
);

  logic [DATA_W-1:0] exp_r, mod_r, acc_r, sq_r, prod_r, res_r;
  logic              div_r;
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   red;
  logic [DATA_W-1:0] mul_b;
  logic              b_bit;

  // multiplicand is always the running square, multiplier bits go msb first
  assign mul_b = cmd.sel_sq ? sq_r : acc_r;
  assign b_bit = mul_b[cmd.mbit];

  // doubling or conditional add, then one compare-subtract keeps it below q
  always_comb begin
    if (cmd.mul_dbl) begin
      sum = {prod_r, 1'b0};
    end else begin
      sum = {1'b0, prod_r} + (b_bit ? {1'b0, sq_r} : '0);
    end
    red = (sum >= {1'b0, mod_r}) ? (sum - {1'b0, mod_r}) : sum;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exp_r <= exponent;
      mod_r <= modulus;
      acc_r <= (modulus > DATA_W'(1)) ? DATA_W'(1) : '0;
      sq_r  <= (modulus > DATA_W'(2)) ? DATA_W'(2) : '0;
    end else begin
      if (cmd.shift_exp) exp_r <= exp_r >> 1;
      if (cmd.wr_acc)    acc_r <= prod_r;
      if (cmd.wr_sq)     sq_r  <= prod_r;
    end
    if (cmd.mul_clr) begin
      prod_r <= '0;
    end else if (cmd.mul_dbl || cmd.mul_add) begin
      prod_r <= red[DATA_W-1:0];
    end
    if (cmd.out_load) begin
      res_r <= acc_r;
      div_r <= (acc_r == DATA_W'(1));
    end
  end

  assign status.exp_lsb   = exp_r[0];
  assign status.exp_zero  = (exp_r == '0);
  assign status.mod_small = (mod_r <= DATA_W'(1));

  assign residue = res_r;
  assign divides = div_r;

endmodule

`default_nettype wire

>>> rtl/mersenne_divisor_check.sv
// ----------------------------------------------------------------------------
// mersenne_divisor_check
// trial divisor test for mersenne numbers: 2^p mod q and a divides flag
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one item: exponent p and candidate divisor q.
//   result channel returns one item per input: residue 2^p mod q in tdata
//   and the divides flag (residue equals 1) in tuser.
//   the block works on one item at a time. per exponent bit it runs a
//   check step, one modular multiply when the bit is set and one modular
//   square; each multiply is a shift-add over 32 multiplier bits (double,
//   then conditional add, each reduced by one compare-subtract) plus one
//   write-back step. scanning covers the exponent bits up to the highest
//   set one and stops early once no set bit remains.
//   a zero or unit modulus finishes without any multiply, with residue 0.
//   the result sits in an output register, so the next item is taken while
//   a finished result still waits; a stalled receiver only holds the block
//   once a second result is ready.
//   reset (synchronous, active low) empties the output and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mersenne_divisor_check
  import mdc_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // exponent [31:0], modulus [63:32]
  // result channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // residue [31:0]
  output logic                        out_tuser   // divides
);

  mdc_cmd_t    cmd;
  mdc_status_t status;

  // sequencer: square-and-multiply scan and multiplier step control
  mdc_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath: operand registers, running square, accumulator, reducer
  mdc_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .exponent (in_tdata[DATA_W-1:0]),
    .modulus  (in_tdata[2*DATA_W-1:DATA_W]),
    .status   (status),
    .residue  (out_tdata),
    .divides  (out_tuser)
  );

`ifndef NO_ASSERTIONS
  // divides flag agrees with the residue
  a_div_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata == OUT_TDATA_W'(1))))
    else $error("divides flag does not match residue");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while busy");

  // a result never appears the cycle after an accept
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid))
    else $error("result raised too early");
`endif

endmodule

`default_nettype wire

>>> tb/sv/mersenne_divisor_check_tb.sv
// ----------------------------------------------------------------------------
// mersenne_divisor_check_tb
// self-checking bench for the mersenne trial divisor block
// ----------------------------------------------------------------------------
// items of exponent and modulus go in through a bursty sender. A local
// square-and-multiply model predicts 2^p mod q and the divides flag for
// every accepted item. Results are checked in order while the receiver
// stalls in random spans. The stimulus starts with corner operands and
// known factors, then runs a random mix that leans toward true divisors.
// ----------------------------------------------------------------------------
`default_nettype none

module mersenne_divisor_check_tb;
  import mdc_pkg::*;

  localparam int unsigned IDLE_LIMIT = 50000;
  localparam int unsigned RAND_ITEMS = 116;

  typedef struct packed {
    logic [DATA_W-1:0] exponent;
    logic [DATA_W-1:0] modulus;
  } trial_t;

  typedef struct packed {
    logic [DATA_W-1:0] residue;
    logic              divides;
  } residue_t;

  typedef enum int {RX_READY, RX_RANDOM, RX_BLOCKED} rx_mode_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  trial_t      trial_q[$];
  residue_t    residue_q[$];
  trial_t      trial;
  residue_t    got;
  residue_t    want;
  logic        in_taken  = 1'b0;
  int unsigned items_total;
  int unsigned items_accepted = 0;
  int unsigned mismatches     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned gap_left       = 0;
  int unsigned burst_left     = 1;
  int unsigned rx_span        = 0;
  rx_mode_t    rx_mode        = RX_READY;

  mersenne_divisor_check u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // exponent [31:0], modulus [63:32]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // residue [31:0]
    .out_tuser  (out_tuser)   // divides
  );

  // right-to-left square-and-multiply, full 64-bit products
  function automatic residue_t pow2_residue(input logic [DATA_W-1:0] p,
                                            input logic [DATA_W-1:0] q);
    residue_t    r;
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] p64;
    logic [63:0] q64;
    int unsigned nbits;
    r     = '0;
    p64   = {32'd0, p};
    q64   = {32'd0, q};
    nbits = (WORD_BITS_DEF > 64) ? 64 : WORD_BITS_DEF;
    if (q64 == 0) return r;
    acc = 64'd1 % q64;
    sq  = 64'd2 % q64;
    for (int k = 0; k < nbits; k++) begin
      if (p64[k]) acc = (acc * sq) % q64;
      sq = (sq * sq) % q64;
    end
    r.residue = acc[DATA_W-1:0];
    r.divides = (acc == 64'd1);
    return r;
  endfunction

  // multiplicative order of 2 modulo a small odd q
  function automatic int unsigned order_of_two(input int unsigned q);
    int unsigned v;
    int unsigned n;
    v = 2 % q;
    n = 1;
    while (v != 1) begin
      v = (v * 2) % q;
      n++;
    end
    return n;
  endfunction

  function automatic logic [DATA_W-1:0] odd_modulus();
    logic [DATA_W-1:0] q;
    q = $urandom | 32'd1;
    if (q == 32'd1) q = 32'd3;
    return q;
  endfunction

  task automatic add_trial(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] q);
    trial_t t;
    t.exponent = p;
    t.modulus  = q;
    trial_q.push_back(t);
  endtask

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender: bursts of items separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (trial_q.size() > 0) begin
        trial = trial_q.pop_front();
        in_tdata  <= {trial.modulus, trial.exponent};
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 8);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            9:          gap_left = $urandom_range(300, 5000);
            default:    gap_left = $urandom_range(1, 300);
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: spans of always ready, coin-flip ready and full stall
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_span = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 4500)
                                        : $urandom_range(16, 3000);
    end
    rx_span--;
    case (rx_mode)
      RX_READY:  out_tready <= 1'b1;
      RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));
      default:   out_tready <= 1'b0;
    endcase
  end

  // predict on input accept, check on output accept
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        residue_q.push_back(pow2_residue(in_tdata[DATA_W-1:0],
                                         in_tdata[2*DATA_W-1:DATA_W]));
        items_accepted++;
      end
      if (out_tvalid && out_tready) begin
        got.residue = out_tdata;
        got.divides = out_tuser;
        if (residue_q.size() == 0) begin
          report($sformatf("unexpected result residue=%0d divides=%0b",
                           got.residue, got.divides));
        end else begin
          want = residue_q.pop_front();
          if (got.residue !== want.residue)
            report($sformatf("residue got %0d want %0d", got.residue, want.residue));
          if (got.divides !== want.divides)
            report($sformatf("divides got %0b want %0b", got.divides, want.divides));
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int unsigned q;
    int unsigned ord;
    // corner operands and known factors
    add_trial(32'd0, 32'd3);
    add_trial(32'd1, 32'd3);
    add_trial(32'd2, 32'd3);            // 3 divides 2^2-1
    add_trial(32'd11, 32'd23);          // 23 divides 2047
    add_trial(32'd29, 32'd233);
    add_trial(32'd23, 32'd47);
    add_trial(32'd31, 32'h7FFF_FFFF);   // the mersenne number itself
    add_trial(32'd32, 32'hFFFF_FFFF);   // 2^32 wraps to 1
    add_trial(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_trial(32'hFFFF_FFFF, 32'hFFFF_FFFE);  // even modulus
    add_trial(32'hFFFF_FFFF, 32'd3);
    add_trial(32'h8000_0001, 32'h8000_0001);
    add_trial(32'd0, 32'hFFFF_FFFF);
    add_trial(32'd5, 32'd0);            // zero modulus
    add_trial(32'd0, 32'd0);
    add_trial(32'hFFFF_FFFF, 32'd0);
    add_trial(32'd7, 32'd1);            // unit modulus
    add_trial(32'd0, 32'd1);
    add_trial(32'd3, 32'd2);
    add_trial(32'd0, 32'd2);
    add_trial(32'd9, 32'd1024);
    add_trial(32'd12345, 32'd6);
    add_trial(32'h5555_5555, 32'hAAAA_AAAB);
    add_trial(32'hAAAA_AAAA, 32'h5555_5555);

    // random mix, leaning toward exponents that give residue one
    repeat (RAND_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          q   = $urandom_range(3, 4095) | 1;
          ord = order_of_two(q);
          if ($urandom_range(0, 1))
            add_trial(ord * $urandom_range(1, 64), q);
          else
            add_trial(ord * $urandom_range(1, 32'hFFFF_FFFF / ord), q);
        end
        7, 8, 9, 10, 11, 12:
          add_trial($urandom, odd_modulus());
        13, 14, 15, 16, 17:
          add_trial($urandom_range(0, 64), odd_modulus());
        default: begin
          case ($urandom_range(0, 3))
            0:       add_trial($urandom, $urandom_range(0, 1));
            1:       add_trial($urandom, $urandom & 32'hFFFF_FFFE);
            default: add_trial($urandom, $urandom);
          endcase
        end
      endcase
    end
    items_total = trial_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_accepted < items_total || residue_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (residue_q.size() > 0) report("results still outstanding at end of run");
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

>>> mersenne_divisor_check.f
rtl/mdc_pkg.sv
rtl/mdc_ctrl.sv
rtl/mdc_dp.sv
rtl/mersenne_divisor_check.sv
tb/sv/mersenne_divisor_check_tb.sv
